[hw/rtl/p2oc_pkg.sv]
// ---------------------------------------------------------------------------
// p2oc_pkg
// Types, register codes and constants shared by the pixel to occupancy
// cell pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package p2oc_pkg;

  localparam int MaxDimDefault = 4096;

  // field widths
  localparam int ChanW = 8;
  localparam int ColW  = 12;
  localparam int DimW  = 13;
  localparam int ThrW  = 16;
  localparam int SumW  = 10;   // up to 4 * 255
  localparam int OccW  = 26;   // up to 1020 * 2^16
  localparam int NumW  = 33;   // up to 99 * 2^26
  localparam int QuoW  = 7;    // quotient never exceeds 99
  localparam int IdxW  = 24;
  localparam int ValW  = 8;

  typedef enum logic [1:0] {
    MODE_TRINARY = 2'd0,
    MODE_SCALE   = 2'd1,
    MODE_RAW     = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_NEGATE   = 3'd1,
    REG_OCC_THR  = 3'd2,
    REG_FREE_THR = 3'd3,
    REG_CHANS    = 3'd4,
    REG_ALPHA    = 3'd5,
    REG_WIDTH    = 3'd6,
    REG_HEIGHT   = 3'd7
  } reg_idx_t;

  localparam logic [1:0]      ModeReset    = 2'd0;
  localparam logic [ThrW-1:0] OccThrReset  = 16'd42598;
  localparam logic [ThrW-1:0] FreeThrReset = 16'd12845;
  localparam logic [2:0]      ChansReset   = 3'd1;
  localparam logic [DimW-1:0] DimReset     = 13'd1;

  localparam logic [ValW-1:0] CellOccupied = 8'd100;
  localparam logic [ValW-1:0] CellFree     = 8'd0;
  localparam logic [ValW-1:0] CellUnknown  = 8'd255;
  localparam logic [ValW-1:0] ScaleTop     = 8'd99;

  typedef struct packed {
    logic [1:0]      mode;
    logic            negate;
    logic [ThrW-1:0] occ_thr;
    logic [ThrW-1:0] free_thr;
    logic [2:0]      chans;
    logic            alpha;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } cfg_t;

  // front end -> classifier
  typedef struct packed {
    logic [OccW-1:0] occ;
    logic [OccW-1:0] hi;
    logic [OccW-1:0] lo;
    logic [ValW-1:0] raw;
    mode_t           mode;
    logic            alpha_zero;
    logic [IdxW-1:0] prod;
    logic [ColW-1:0] col;
  } front_t;

  // classifier -> divider
  typedef struct packed {
    logic [ValW-1:0] value;
    logic            need_div;
    logic [NumW-1:0] num;
    logic [OccW-1:0] span;
    logic [IdxW-1:0] idx;
  } class_t;

endpackage

`default_nettype wire

[hw/rtl/p2oc_cfg.sv]
// ---------------------------------------------------------------------------
// p2oc_cfg
// APB register file holding the mode, negate, thresholds, channel count, alpha and image geometry.
// ---------------------------------------------------------------------------
`default_nettype none

module p2oc_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output p2oc_pkg::cfg_t         cfg
);

  p2oc_pkg::reg_idx_t idx;

  assign idx    = p2oc_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= p2oc_pkg::ModeReset;
      cfg.negate   <= 1'b0;
      cfg.occ_thr  <= p2oc_pkg::OccThrReset;
      cfg.free_thr <= p2oc_pkg::FreeThrReset;
      cfg.chans    <= p2oc_pkg::ChansReset;
      cfg.alpha    <= 1'b0;
      cfg.width    <= p2oc_pkg::DimReset;
      cfg.height   <= p2oc_pkg::DimReset;
    end else if (psel && penable && pwrite) begin
      case (idx)
        p2oc_pkg::REG_MODE:     cfg.mode     <= pwdata[1:0];
        p2oc_pkg::REG_NEGATE:   cfg.negate   <= pwdata[0];
        p2oc_pkg::REG_OCC_THR:  cfg.occ_thr  <= pwdata[15:0];
        p2oc_pkg::REG_FREE_THR: cfg.free_thr <= pwdata[15:0];
        p2oc_pkg::REG_CHANS:    cfg.chans    <= pwdata[2:0];
        p2oc_pkg::REG_ALPHA:    cfg.alpha    <= pwdata[0];
        p2oc_pkg::REG_WIDTH:    cfg.width    <= pwdata[12:0];
        p2oc_pkg::REG_HEIGHT:   cfg.height   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      p2oc_pkg::REG_MODE:     prdata = 32'(cfg.mode);
      p2oc_pkg::REG_NEGATE:   prdata = 32'(cfg.negate);
      p2oc_pkg::REG_OCC_THR:  prdata = 32'(cfg.occ_thr);
      p2oc_pkg::REG_FREE_THR: prdata = 32'(cfg.free_thr);
      p2oc_pkg::REG_CHANS:    prdata = 32'(cfg.chans);
      p2oc_pkg::REG_ALPHA:    prdata = 32'(cfg.alpha);
      p2oc_pkg::REG_WIDTH:    prdata = 32'(cfg.width);
      p2oc_pkg::REG_HEIGHT:   prdata = 32'(cfg.height);
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/p2oc_front.sv]
// ---------------------------------------------------------------------------
// p2oc_front
// Two stages: channel sum and flipped row, then occupancy and threshold
// products, raw average and the row product of the cell index.
// ---------------------------------------------------------------------------
`default_nettype none

module p2oc_front #(
  parameter int MAX_DIM = p2oc_pkg::MaxDimDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire p2oc_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [p2oc_pkg::ChanW-1:0]    chan0,
  input  wire logic [p2oc_pkg::ChanW-1:0]    chan1,
  input  wire logic [p2oc_pkg::ChanW-1:0]    chan2,
  input  wire logic [p2oc_pkg::ChanW-1:0]    chan3,
  input  wire logic [p2oc_pkg::ColW-1:0]     pixel_col,
  input  wire logic [p2oc_pkg::ColW-1:0]     pixel_row,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output p2oc_pkg::front_t                   out_data
);

  localparam logic [p2oc_pkg::DimW-1:0] DimCap =
    (MAX_DIM > 8191) ? 13'h1FFF : 13'(MAX_DIM);

  typedef struct packed {
    logic [p2oc_pkg::SumW-1:0] t;
    logic [2:0]                a;
    p2oc_pkg::mode_t           mode;
    logic                      alpha_zero;
    logic [p2oc_pkg::IdxW-1:0] hrow;
    logic [p2oc_pkg::DimW-1:0] w;
    logic [p2oc_pkg::ColW-1:0] col;
  } front_s1_t;

  logic [1:0]                 v;
  logic [1:0]                 rdy;
  front_s1_t                  s1, s1_next;
  p2oc_pkg::front_t           s2_next;

  logic [3:0][p2oc_pkg::ChanW-1:0] bytes;
  logic [2:0]                 n;
  logic [2:0]                 a;
  p2oc_pkg::mode_t            mode_eff;
  logic [p2oc_pkg::SumW-1:0]  sum;
  logic [p2oc_pkg::SumW-1:0]  den1;
  logic [p2oc_pkg::SumW-1:0]  den2;
  logic [p2oc_pkg::SumW-1:0]  u;
  logic [p2oc_pkg::DimW-1:0]  w_c;
  logic [p2oc_pkg::DimW-1:0]  h_c;
  logic [19:0]                third;
  logic [36:0]                row_prod;

  // per-stage ready: a stage loads when empty or when its successor moves
  assign rdy[1]    = !v[1] || !out_stall;
  assign rdy[0]    = !v[0] || rdy[1];
  assign in_stall  = !rdy[0];
  assign out_valid = v[1];

  assign bytes = {chan3, chan2, chan1, chan0};

  // stage 1: channel sum, optional negation, flipped row
  always_comb begin
    n = cfg.chans;
    if (n == 3'd0) begin
      n = 3'd1;
    end else if (n > 3'd4) begin
      n = 3'd4;
    end
    case (cfg.mode)
      p2oc_pkg::MODE_SCALE: mode_eff = p2oc_pkg::MODE_SCALE;
      p2oc_pkg::MODE_RAW:   mode_eff = p2oc_pkg::MODE_RAW;
      default:              mode_eff = p2oc_pkg::MODE_TRINARY;
    endcase
    a = (mode_eff != p2oc_pkg::MODE_TRINARY && cfg.alpha && n > 3'd1) ? n - 3'd1 : n;
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < a) begin
        sum = sum + p2oc_pkg::SumW'(bytes[k]);
      end
    end
    den1 = p2oc_pkg::SumW'(11'({a, 8'd0}) - 11'(a));
    w_c  = (cfg.width  > DimCap) ? DimCap : cfg.width;
    h_c  = (cfg.height > DimCap) ? DimCap : cfg.height;

    s1_next.t    = cfg.negate ? den1 - sum : sum;
    s1_next.a    = a;
    s1_next.mode = mode_eff;
    case (n)
      3'd2:    s1_next.alpha_zero = (chan1 == '0);
      3'd3:    s1_next.alpha_zero = (chan2 == '0);
      3'd4:    s1_next.alpha_zero = (chan3 == '0);
      default: s1_next.alpha_zero = 1'b0;
    endcase
    s1_next.hrow = p2oc_pkg::IdxW'(h_c) - 24'd1 - p2oc_pkg::IdxW'(pixel_row);
    s1_next.w    = w_c;
    s1_next.col  = pixel_col;
  end

  // stage 2: occupancy numerator, threshold products, raw average, row product
  always_comb begin
    den2  = p2oc_pkg::SumW'(11'({s1.a, 8'd0}) - 11'(s1.a));
    u     = den2 - s1.t;
    third = 20'(s1.t) * 20'd683;   // floor(t/3) for t up to 1020
    row_prod = 37'(s1.w) * 37'(s1.hrow);

    s2_next.occ = {u, 16'd0};
    s2_next.hi  = p2oc_pkg::OccW'(cfg.occ_thr)  * p2oc_pkg::OccW'(den2);
    s2_next.lo  = p2oc_pkg::OccW'(cfg.free_thr) * p2oc_pkg::OccW'(den2);
    case (s1.a)
      3'd1:    s2_next.raw = s1.t[7:0];
      3'd2:    s2_next.raw = s1.t[8:1];
      3'd3:    s2_next.raw = third[18:11];
      default: s2_next.raw = s1.t[9:2];
    endcase
    s2_next.mode       = s1.mode;
    s2_next.alpha_zero = s1.alpha_zero;
    s2_next.prod       = row_prod[p2oc_pkg::IdxW-1:0];
    s2_next.col        = s1.col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) s1       <= s1_next;
    if (rdy[1]) out_data <= s2_next;
  end

endmodule

`default_nettype wire

[hw/rtl/p2oc_class.sv]
// ---------------------------------------------------------------------------
// p2oc_class
// Two stages: threshold compares and cell decision, then the scaled
// numerator 99 * (occ - lo) for the divider.
// ---------------------------------------------------------------------------
`default_nettype none

module p2oc_class (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire p2oc_pkg::front_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output p2oc_pkg::class_t  out_data
);

  typedef struct packed {
    logic [p2oc_pkg::ValW-1:0] value;
    logic                      need_div;
    logic [p2oc_pkg::OccW-1:0] diff;
    logic [p2oc_pkg::OccW-1:0] span;
    logic [p2oc_pkg::IdxW-1:0] idx;
  } class_s1_t;

  logic [1:0]       v;
  logic [1:0]       rdy;
  class_s1_t        s1, s1_next;
  p2oc_pkg::class_t s2_next;

  assign rdy[1]    = !v[1] || !out_stall;
  assign rdy[0]    = !v[0] || rdy[1];
  assign in_stall  = !rdy[0];
  assign out_valid = v[1];

  always_comb begin
    s1_next.need_div = 1'b0;
    s1_next.diff     = in_data.occ - in_data.lo;
    s1_next.span     = in_data.hi - in_data.lo;
    s1_next.idx      = in_data.prod + p2oc_pkg::IdxW'(in_data.col);
    if (in_data.mode == p2oc_pkg::MODE_RAW) begin
      s1_next.value = in_data.raw;
    end else if (in_data.occ > in_data.hi) begin
      s1_next.value = p2oc_pkg::CellOccupied;
    end else if (in_data.occ < in_data.lo) begin
      s1_next.value = p2oc_pkg::CellFree;
    end else if (in_data.mode == p2oc_pkg::MODE_TRINARY || in_data.alpha_zero) begin
      s1_next.value = p2oc_pkg::CellUnknown;
    end else if (in_data.hi <= in_data.lo) begin
      // empty threshold band
      s1_next.value = p2oc_pkg::CellFree;
    end else begin
      s1_next.value    = p2oc_pkg::CellFree;
      s1_next.need_div = 1'b1;
    end
  end

  always_comb begin
    s2_next.value    = s1.value;
    s2_next.need_div = s1.need_div;
    s2_next.num      = p2oc_pkg::NumW'(s1.diff) * p2oc_pkg::NumW'(p2oc_pkg::ScaleTop);
    s2_next.span     = s1.span;
    s2_next.idx      = s1.idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) s1       <= s1_next;
    if (rdy[1]) out_data <= s2_next;
  end

  a_band_order: assert property (@(posedge clk) disable iff (rst)
    v[0] && s1.need_div |-> s1.diff <= s1.span)
    else $error("scale request with numerator above threshold span");

endmodule

`default_nettype wire

[hw/rtl/p2oc_div.sv]
// ---------------------------------------------------------------------------
// p2oc_div
// Pipelined restoring divider, one quotient bit per stage. The last stage
// picks the quotient or the value decided upstream and is the output
// register of the block.
// ---------------------------------------------------------------------------
`default_nettype none

module p2oc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire p2oc_pkg::class_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [p2oc_pkg::ValW-1:0]        value,
  output logic [p2oc_pkg::IdxW-1:0]        idx
);

  localparam int NS = p2oc_pkg::QuoW;

  typedef struct packed {
    logic [p2oc_pkg::NumW-1:0] rem;
    logic [p2oc_pkg::QuoW-1:0] q;
    logic [p2oc_pkg::OccW-1:0] span;
    logic                      need_div;
    logic [p2oc_pkg::ValW-1:0] value;
    logic [p2oc_pkg::IdxW-1:0] idx;
  } div_stage_t;

  logic [NS-1:0] v;
  logic [NS-1:0] rdy;
  div_stage_t    st      [NS];
  div_stage_t    st_next [NS];
  div_stage_t    head;

  always_comb begin
    rdy[NS-1] = !v[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v[NS-1];
  assign value     = st[NS-1].value;
  assign idx       = st[NS-1].idx;

  always_comb begin
    head.rem      = in_data.num;
    head.q        = '0;
    head.span     = in_data.span;
    head.need_div = in_data.need_div;
    head.value    = in_data.value;
    head.idx      = in_data.idx;
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    div_stage_t                prev;
    logic [p2oc_pkg::NumW-1:0] sub;
    logic                      take;

    if (k == 0) begin : g_first
      assign prev = head;
    end else begin : g_rest
      assign prev = st[k-1];
    end

    always_comb begin
      sub  = p2oc_pkg::NumW'(prev.span) << (NS - 1 - k);
      take = prev.rem >= sub;
      st_next[k]      = prev;
      st_next[k].rem  = take ? prev.rem - sub : prev.rem;
      st_next[k].q    = prev.q | (p2oc_pkg::QuoW'(take) << (NS - 1 - k));
      if (k == NS - 1 && prev.need_div) begin
        st_next[k].value = p2oc_pkg::ValW'(st_next[k].q);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) st[k] <= st_next[k];
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v[NS-1] && st[NS-1].need_div |-> st[NS-1].rem < p2oc_pkg::NumW'(st[NS-1].span))
    else $error("divider remainder not below divisor");

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    v[NS-1] && st[NS-1].need_div |-> st[NS-1].value <= p2oc_pkg::ScaleTop)
    else $error("scaled cell value above 99");

endmodule

`default_nettype wire

[hw/rtl/pixel_to_occupancy_cell.sv]
// ---------------------------------------------------------------------------
// pixel_to_occupancy_cell
// Converts one image pixel into an occupancy grid cell value and its index
// in a vertically flipped grid.
// ---------------------------------------------------------------------------
//  channel  valid        stall        payload
//  pixel    pixel_valid  pixel_stall  chan0..chan3, pixel_col, pixel_row
//  cell     cell_valid   cell_stall   cell_value, cell_index
//  config   psel/penable pready (=1)  paddr, pwdata, prdata (APB)
//
// One pixel per clock sustained while cell_stall is low. The pipeline has two front-end
// stages, two classification stages and seven divider stages, one quotient bit each.
// Every stage has its own valid bit and loads when empty or when its
// successor moves, so bubbles close up under a stalled output.
// Synchronous reset restores register defaults and empties the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module pixel_to_occupancy_cell #(
  parameter int MAX_DIM = p2oc_pkg::MaxDimDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        pixel_valid,
  output logic             pixel_stall,
  input  wire logic [7:0]  chan0,
  input  wire logic [7:0]  chan1,
  input  wire logic [7:0]  chan2,
  input  wire logic [7:0]  chan3,
  input  wire logic [11:0] pixel_col,
  input  wire logic [11:0] pixel_row,
  output logic             cell_valid,
  input  wire logic        cell_stall,
  output logic [7:0]       cell_value,
  output logic [23:0]      cell_index
);

  p2oc_pkg::cfg_t   cfg;
  p2oc_pkg::front_t front_data;
  p2oc_pkg::class_t class_data;
  logic             front_valid, front_stall;
  logic             class_valid, class_stall;

  p2oc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  p2oc_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pixel_valid),
    .in_stall  (pixel_stall),
    .chan0     (chan0),
    .chan1     (chan1),
    .chan2     (chan2),
    .chan3     (chan3),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .out_valid (front_valid),
    .out_stall (front_stall),
    .out_data  (front_data)
  );

  p2oc_class u_class (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_stall  (front_stall),
    .in_data   (front_data),
    .out_valid (class_valid),
    .out_stall (class_stall),
    .out_data  (class_data)
  );

  p2oc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (class_valid),
    .in_stall  (class_stall),
    .in_data   (class_data),
    .out_valid (cell_valid),
    .out_stall (cell_stall),
    .value     (cell_value),
    .idx       (cell_index)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !cell_valid)
    else $error("cell request present right after reset");

endmodule

`default_nettype wire
